// File: rtl/md5sh_pkg.sv
// Shared types, constants and step tables for the MD5 stream hash engine.
package md5sh_pkg;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MARK = 7'b0000010,
    ST_ZERO = 7'b0000100,
    ST_LEN  = 7'b0001000,
    ST_COMP = 7'b0010000,
    ST_ADD  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
  localparam logic [6:0] LEN_FIELD_POS = 7'd56;
  localparam logic [6:0] BLOCK_END_POS = 7'd64;

  // Additive constant for each of the 64 steps
  function automatic logic [31:0] step_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  6'd63: k = 32'hEB86D391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Rotate amount, indexed by {round, step[1:0]}
  function automatic logic [4:0] rot_amount(input logic [3:0] idx);
    logic [4:0] s;
    case (idx)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] wide;
    wide = {x, x} << n;
    return wide[63:32];
  endfunction

endpackage

// File: rtl/md5_stream_hash_top.sv
// MD5 stream hash engine: byte-wide input, four 32-bit digest words out.
//
// Input channel: in_valid / in_stall with in_data_byte, in_byte_present and
// in_end_of_message. Each item carries at most one message byte; the item
// that sets in_end_of_message closes the message (it may carry a byte too,
// or none, which is how an empty message is sent).
// Result channel: out_valid / out_stall. For each message four items are
// sent, words A, B, C, D in that order, with out_word_number 0..3 and
// out_final_word high on D. Each word holds its digest bytes little-endian.
// Throughput: the 64th byte of a block starts the compression, which runs one step
// per cycle through a single shared round datapath (64 steps, then a fold into
// the chaining words). in_stall stays high while the sequencer is busy, so no
// new item is taken until the block is done.
// From the end item to word A the sequencer places the 0x80 mark, writes the zero
// pad bytes, closes the fill, writes the 8-byte bit length and runs the compression;
// a mark past byte 55 pads and compresses a block first.
// Words are presented from registers and held while out_stall is high.
// Reset (rst_n low, synchronous) reloads the initial chaining words, clears
// the bit count and returns the sequencer to idle.
module md5_stream_hash_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_number,
  output logic        out_final_word
);

  md5sh_pkg::state_t state_r, state_nxt;

  // Block buffer: 16 little-endian words, written a byte at a time
  logic [31:0] blk_r [16];

  logic [31:0] h_r [4];
  logic [31:0] h_nxt [4];
  logic [63:0] len_r, len_nxt;
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [6:0]  bp_r, bp_nxt;       // padding byte position, 0..64
  logic [1:0]  wn_r, wn_nxt;
  logic        eom_r, eom_nxt;     // end item seen, padding still to do
  logic        pad_r, pad_nxt;     // mark placed, padding under way
  logic        lenblk_r, lenblk_nxt; // last block (with bit length) compressing

  // Byte write port into the block buffer
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;

  logic        start_comp;

  // Round datapath
  logic [1:0]  rnd;
  logic [3:0]  i4;
  logic [3:0]  g;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] t;
  logic [5:0]  fill_pos;
  logic        in_acc;
  logic        out_acc;

  assign fill_pos = len_r[8:3];
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  assign in_stall        = (state_r != md5sh_pkg::ST_IDLE);
  assign out_valid       = (state_r == md5sh_pkg::ST_OUT);
  assign out_digest_word = h_r[wn_r];
  assign out_word_number = wn_r;
  assign out_final_word  = (wn_r == 2'd3);

  // One MD5 step: round function, message word select, add, rotate
  always_comb begin
    rnd = step_r[5:4];
    i4  = step_r[3:0];
    case (rnd)
      2'd0: begin
        f = (b_r & c_r) | (~b_r & d_r);
        g = i4;
      end
      2'd1: begin
        f = (b_r & d_r) | (c_r & ~d_r);
        g = i4 * 4'd5 + 4'd1;
      end
      2'd2: begin
        f = b_r ^ c_r ^ d_r;
        g = i4 * 4'd3 + 4'd5;
      end
      default: begin
        f = c_r ^ (b_r | ~d_r);
        g = i4 * 4'd7;
      end
    endcase
    sum = a_r + f + blk_r[g] + md5sh_pkg::step_const(step_r);
    t   = md5sh_pkg::rotl32(sum, md5sh_pkg::rot_amount({rnd, step_r[1:0]})) + b_r;
  end

  always_comb begin
    state_nxt  = state_r;
    h_nxt      = h_r;
    len_nxt    = len_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    step_nxt   = step_r;
    bp_nxt     = bp_r;
    wn_nxt     = wn_r;
    eom_nxt    = eom_r;
    pad_nxt    = pad_r;
    lenblk_nxt = lenblk_r;
    wr_en      = 1'b0;
    wr_pos     = fill_pos;
    wr_byte    = in_data_byte;
    start_comp = 1'b0;

    case (state_r)
      md5sh_pkg::ST_IDLE: begin
        if (in_acc) begin
          eom_nxt = in_end_of_message;
          if (in_byte_present) begin
            wr_en   = 1'b1;
            len_nxt = len_r + 64'd8;
          end
          if (in_byte_present && (fill_pos == 6'd63)) begin
            start_comp = 1'b1;
          end else if (in_end_of_message) begin
            state_nxt = md5sh_pkg::ST_MARK;
          end
        end
      end

      md5sh_pkg::ST_MARK: begin
        // Place the 0x80 mark just after the last message byte
        wr_en   = 1'b1;
        wr_byte = md5sh_pkg::PAD_MARK_BYTE;
        bp_nxt  = {1'b0, fill_pos} + 7'd1;
        pad_nxt = 1'b1;
        state_nxt = md5sh_pkg::ST_ZERO;
      end

      md5sh_pkg::ST_ZERO: begin
        if (bp_r == md5sh_pkg::LEN_FIELD_POS) begin
          state_nxt = md5sh_pkg::ST_LEN;
        end else if (bp_r == md5sh_pkg::BLOCK_END_POS) begin
          // Mark fell past the length field: flush this block first
          start_comp = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_pos  = bp_r[5:0];
          wr_byte = 8'h00;
          bp_nxt  = bp_r + 7'd1;
        end
      end

      md5sh_pkg::ST_LEN: begin
        wr_en   = 1'b1;
        wr_pos  = bp_r[5:0];
        wr_byte = len_r[8 * bp_r[2:0] +: 8];
        bp_nxt  = bp_r + 7'd1;
        if (bp_r[5:0] == 6'd63) begin
          lenblk_nxt = 1'b1;
          start_comp = 1'b1;
        end
      end

      md5sh_pkg::ST_COMP: begin
        a_nxt    = d_r;
        b_nxt    = t;
        c_nxt    = b_r;
        d_nxt    = c_r;
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd63) begin
          state_nxt = md5sh_pkg::ST_ADD;
        end
      end

      md5sh_pkg::ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        if (lenblk_r) begin
          wn_nxt    = 2'd0;
          state_nxt = md5sh_pkg::ST_OUT;
        end else if (pad_r) begin
          bp_nxt    = 7'd0;
          state_nxt = md5sh_pkg::ST_ZERO;
        end else if (eom_r) begin
          state_nxt = md5sh_pkg::ST_MARK;
        end else begin
          state_nxt = md5sh_pkg::ST_IDLE;
        end
      end

      md5sh_pkg::ST_OUT: begin
        if (out_acc) begin
          wn_nxt = wn_r + 2'd1;
          if (wn_r == 2'd3) begin
            // Re-initialise for the next message
            h_nxt[0]   = md5sh_pkg::INIT_A;
            h_nxt[1]   = md5sh_pkg::INIT_B;
            h_nxt[2]   = md5sh_pkg::INIT_C;
            h_nxt[3]   = md5sh_pkg::INIT_D;
            len_nxt    = 64'd0;
            eom_nxt    = 1'b0;
            pad_nxt    = 1'b0;
            lenblk_nxt = 1'b0;
            state_nxt  = md5sh_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = md5sh_pkg::ST_IDLE;
      end
    endcase

    if (start_comp) begin
      a_nxt     = h_r[0];
      b_nxt     = h_r[1];
      c_nxt     = h_r[2];
      d_nxt     = h_r[3];
      step_nxt  = 6'd0;
      state_nxt = md5sh_pkg::ST_COMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= md5sh_pkg::ST_IDLE;
      h_r[0]   <= md5sh_pkg::INIT_A;
      h_r[1]   <= md5sh_pkg::INIT_B;
      h_r[2]   <= md5sh_pkg::INIT_C;
      h_r[3]   <= md5sh_pkg::INIT_D;
      len_r    <= 64'd0;
      step_r   <= 6'd0;
      bp_r     <= 7'd0;
      wn_r     <= 2'd0;
      eom_r    <= 1'b0;
      pad_r    <= 1'b0;
      lenblk_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      h_r      <= h_nxt;
      len_r    <= len_nxt;
      step_r   <= step_nxt;
      bp_r     <= bp_nxt;
      wn_r     <= wn_nxt;
      eom_r    <= eom_nxt;
      pad_r    <= pad_nxt;
      lenblk_r <= lenblk_nxt;
    end
  end

  // Working words and block buffer carry no reset
  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    if (wr_en) begin
      blk_r[wr_pos[5:2]][8 * wr_pos[1:0] +: 8] <= wr_byte;
    end
  end

endmodule

// File: tb/sv/md5_digest_checker.sv
// Digest checker: tracks the MD5 message state and compares every digest word.
module md5_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_present,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [1:0]  out_word_number,
  input  logic        out_final_word,
  output int          pending_words,
  output int          error_count
);

  localparam logic [1:0] LAST_WORD = 2'd3;

  localparam logic [3:0][31:0] START_WORDS = {
    32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [0:63][31:0] STEP_K = {
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [0:15][4:0] ROT_BY = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  number;
    logic        final_flag;
  } digest_word_t;

  logic [3:0][31:0] chain;
  logic [63:0][7:0] block_bytes;
  logic [63:0]      msg_bits;
  digest_word_t     digest_q[$];
  int               errs;

  // One 64-step compression, folded into the chaining words
  function automatic logic [3:0][31:0] fold_block(input logic [3:0][31:0] h,
                                                  input logic [63:0][7:0] blk);
    logic [31:0] a, b, c, d, f, t, m;
    logic [4:0]  s;
    int          i, g, r;
    a = h[0];
    b = h[1];
    c = h[2];
    d = h[3];
    for (i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      m = {blk[4*g+3], blk[4*g+2], blk[4*g+1], blk[4*g]};
      t = a + f + m + STEP_K[i];
      s = ROT_BY[r*4 + i%4];
      t = ((t << s) | (t >> (32 - s))) + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    return {h[3] + d, h[2] + c, h[1] + b, h[0] + a};
  endfunction

  task automatic absorb_item(input logic [7:0] data, input logic present, input logic last);
    int pos, k;
    digest_word_t dw;
    if (present) begin
      pos = int'(msg_bits[8:3]);
      block_bytes[pos] = data;
      msg_bits = msg_bits + 64'd8;
      if (pos == 63) chain = fold_block(chain, block_bytes);
    end
    if (last) begin
      pos = int'(msg_bits[8:3]);
      block_bytes[pos] = 8'h80;
      pos = pos + 1;
      // no room for the length: pad out this block and start a fresh one
      if (pos > 56) begin
        while (pos < 64) begin
          block_bytes[pos] = 8'h00;
          pos = pos + 1;
        end
        chain = fold_block(chain, block_bytes);
        pos = 0;
      end
      while (pos < 56) begin
        block_bytes[pos] = 8'h00;
        pos = pos + 1;
      end
      for (k = 0; k < 8; k++) block_bytes[56+k] = msg_bits[8*k +: 8];
      chain = fold_block(chain, block_bytes);
      for (k = 0; k < 4; k++) begin
        dw.word = chain[k];
        dw.number = k[1:0];
        dw.final_flag = (k[1:0] == LAST_WORD);
        digest_q.push_back(dw);
      end
      chain = START_WORDS;
      msg_bits = '0;
    end
  endtask

  task automatic check_word();
    digest_word_t dw;
    if (digest_q.size() == 0) begin
      $error("unexpected digest word %h (word_number %0d)", out_digest_word, out_word_number);
      errs++;
    end else begin
      dw = digest_q.pop_front();
      if (out_digest_word !== dw.word) begin
        $error("digest_word: expected %h, actual %h", dw.word, out_digest_word);
        errs++;
      end
      if (out_word_number !== dw.number) begin
        $error("word_number: expected %0d, actual %0d", dw.number, out_word_number);
        errs++;
      end
      if (out_final_word !== dw.final_flag) begin
        $error("final_word: expected %0b, actual %0b", dw.final_flag, out_final_word);
        errs++;
      end
    end
  endtask

  initial begin
    errs = 0;
    chain = START_WORDS;
    block_bytes = '0;
    msg_bits = '0;
    pending_words = 0;
    error_count = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      chain = START_WORDS;
      msg_bits = '0;
      digest_q.delete();
    end else begin
      if (out_valid && !out_stall) check_word();
      if (in_valid && !in_stall) absorb_item(in_data_byte, in_byte_present, in_end_of_message);
    end
    pending_words <= digest_q.size();
    error_count <= errs;
  end

endmodule

// File: tb/sv/tb_md5_stream_hash_top.sv
// Testbench top: drives message items into the MD5 engine and gives the verdict.
module tb_md5_stream_hash_top;

  // Generous bound: ~470 items and a few dozen padded messages, plus random
  // idling on both sides, taken many times over.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 250;
  localparam int ITEM_TARGET  = 470;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_byte_present = 1'b0;
  logic        in_end_of_message = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [31:0] out_digest_word;
  logic [1:0]  out_word_number;
  logic        out_final_word;

  int pending_words;
  int error_count;
  int cycle_count = 0;
  int idle_pct = 25;   // percentage of cycles each side spends idle
  int items_sent = 0;  // items that carry a byte or close a message

  md5_stream_hash_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_final_word    (out_final_word)
  );

  md5_digest_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_byte      (in_data_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_word   (out_digest_word),
    .out_word_number   (out_word_number),
    .out_final_word    (out_final_word),
    .pending_words     (pending_words),
    .error_count       (error_count)
  );

  // 12-unit clock period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: give up if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_md5_stream_hash_top: errors");
      $finish;
    end
  end

  // Stall the result side at random, at the same rate as the sender idles
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // Offer one item: idle for a random spell, then hold the item until taken.
  // Valid is left high on return so back-to-back items need no gap.
  task automatic push_item(input logic [7:0] data, input logic present, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_byte_present <= present;
    in_end_of_message <= last;
    do @(posedge clk); while (in_stall);
    if (present || last) items_sent++;
  endtask

  // Drop valid and hold off until every digest word has come out
  task automatic wait_for_digests();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  // Send a message of random bytes; the last byte rides on the end item when
  // tail_on_end is set, otherwise a separate byte-less end item closes it.
  // Sprinkle byte-less, mark-less items in between to check they are ignored.
  task automatic send_message(input int len, input bit tail_on_end);
    int k;
    for (k = 0; k < len; k++) begin
      push_item(8'($urandom_range(255)), 1'b1, (k == len - 1) && tail_on_end);
      if ($urandom_range(99) < 6) push_item(8'($urandom_range(255)), 1'b0, 1'b0);
    end
    if (len == 0 || !tail_on_end) push_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  function automatic int pick_length();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return $urandom_range(0, 24);
    // lengths around the padding and block boundaries
    if (sel < 85) begin
      case ($urandom_range(7))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(25, 140);
  endfunction

  initial begin
    int msg_count;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty messages back to back, a junk byte on the end item
    push_item(8'hA5, 1'b0, 1'b1);
    push_item(8'h00, 1'b0, 1'b1);
    // an ignored item, then the extreme byte values with the last on the end item
    push_item(8'h5A, 1'b0, 1'b0);
    push_item(8'h00, 1'b1, 1'b0);
    push_item(8'hFF, 1'b1, 1'b1);
    // "abc"
    push_item(8'h61, 1'b1, 1'b0);
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    // bytes closed by a byte-less end item
    push_item(8'h80, 1'b1, 1'b0);
    push_item(8'h7F, 1'b1, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    wait_for_digests();

    // Random messages; a stretch with no idling, and a full hold-off midway
    msg_count = 0;
    while (items_sent < ITEM_TARGET) begin
      if (msg_count == 4) idle_pct = 0;
      if (msg_count == 8) idle_pct = 25;
      send_message(pick_length(), 1'($urandom_range(1)));
      if (msg_count == 10) wait_for_digests();
      msg_count++;
    end

    // Drain, then let the engine settle before the verdict
    wait_for_digests();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_md5_stream_hash_top: clean");
    end else begin
      $display("tb_md5_stream_hash_top: errors");
    end
    $finish;
  end

endmodule
